// ===== design/ale_pkg.sv =====
// Shared types, codes and defaults for the array list engine.
`timescale 1ns / 1ps

package ale_pkg;

    // Default number of list entries
    localparam int ALE_CAPACITY = 32;

    // Operation codes carried in the mode field
    localparam logic [3:0] MODE_PREPEND   = 4'd0;
    localparam logic [3:0] MODE_APPEND    = 4'd1;
    localparam logic [3:0] MODE_INSERT    = 4'd2;
    localparam logic [3:0] MODE_DEL_FIRST = 4'd3;
    localparam logic [3:0] MODE_DEL_LAST  = 4'd4;
    localparam logic [3:0] MODE_DEL_AT    = 4'd5;
    localparam logic [3:0] MODE_SORT      = 4'd6;
    localparam logic [3:0] MODE_REVERSE   = 4'd7;
    localparam logic [3:0] MODE_READ      = 4'd8;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Index counter operations
    localparam logic [2:0] K_HOLD = 3'd0;
    localparam logic [2:0] K_CNT  = 3'd1;
    localparam logic [2:0] K_TPOS = 3'd2;
    localparam logic [2:0] K_ZERO = 3'd3;
    localparam logic [2:0] K_INC  = 3'd4;
    localparam logic [2:0] K_DEC  = 3'd5;

    // Memory read address sources
    localparam logic [2:0] RA_KM1  = 3'd0;
    localparam logic [2:0] RA_KP1  = 3'd1;
    localparam logic [2:0] RA_K    = 3'd2;
    localparam logic [2:0] RA_TPOS = 3'd3;
    localparam logic [2:0] RA_ZERO = 3'd4;
    localparam logic [2:0] RA_MIR  = 3'd5;

    // Memory write address sources
    localparam logic [1:0] WA_K    = 2'd0;
    localparam logic [1:0] WA_TPOS = 2'd1;
    localparam logic [1:0] WA_MIR  = 2'd2;

    // Memory write data sources
    localparam logic [1:0] WD_VALUE = 2'd0;
    localparam logic [1:0] WD_RDATA = 2'd1;
    localparam logic [1:0] WD_MIN   = 2'd2;
    localparam logic [1:0] WD_A     = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic [2:0] k_op;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       wr_en;
        logic [1:0] wr_asel;
        logic [1:0] wr_dsel;
        logic       cap_a;
        logic       a_max;
        logic       lim_load;
        logic       lim_dec;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_stat;
        logic [1:0] stat;
        logic       take_rd;
        logic       out_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [3:0] mode;
        logic       cnt_zero;
        logic       cnt_full;
        logic       tpos_gt_cnt;
        logic       tpos_ge_cnt;
        logic       k_gt_tpos;
        logic       k_p1_lt_cnt;
        logic       k_lt_half;
        logic       lim_zero;
        logic       k_eq_lim;
        logic       out_free;
    } t_stat;

endpackage

// ===== design/array_list_engine.sv =====
// Top level of the array list engine: controller plus datapath.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_mode, i_value, i_position
//  out     | output    | o_out_valid / i_out_ready  | o_status, o_read_value, o_count
//
// One item at a time, one result each; every item is accepted, decoded and handed off to
// the output register. Rejected and unused operations go straight from decode to the hand-off,
// and a read waits for its memory word. Insert and delete move each entry with a read and a write,
// reverse swaps pairs of entries, and sort is a bubble sort (an empty list goes straight to the hand-off).
// Reset clears the count and the output valid; memory contents are not cleared.
// A waiting result does not block the next item; a new result holds until it frees.
`timescale 1ns / 1ps

module array_list_engine import ale_pkg::*; #(
    parameter int CAPACITY = ALE_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_position,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic [5:0]         o_count
);

    t_cmd  w_cmd;
    t_stat w_stat;

    ale_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ale_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_position   (i_position),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

endmodule

// ===== design/ale_ctrl.sv =====
// Sequencing state machine of the array list engine.
`timescale 1ns / 1ps

module ale_ctrl import ale_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_INS_CHK  = 4'd2;
    localparam logic [3:0] S_INS_WR   = 4'd3;
    localparam logic [3:0] S_DEL_CHK  = 4'd4;
    localparam logic [3:0] S_DEL_WR   = 4'd5;
    localparam logic [3:0] S_SRT_PASS = 4'd6;
    localparam logic [3:0] S_SRT_A    = 4'd7;
    localparam logic [3:0] S_SRT_B    = 4'd8;
    localparam logic [3:0] S_SRT_NX   = 4'd9;
    localparam logic [3:0] S_REV_CHK  = 4'd10;
    localparam logic [3:0] S_REV_RA   = 4'd11;
    localparam logic [3:0] S_REV_RB   = 4'd12;
    localparam logic [3:0] S_REV_WB   = 4'd13;
    localparam logic [3:0] S_RD_WT    = 4'd14;
    localparam logic [3:0] S_FIN      = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_stat = 1'b1;
                o_cmd.stat     = ST_OK;
                n_state        = S_FIN;
                unique case (i_stat.mode)
                    MODE_PREPEND, MODE_APPEND, MODE_INSERT: begin
                        if (i_stat.cnt_full) begin
                            o_cmd.stat = ST_FULL;
                        end else if (i_stat.tpos_gt_cnt) begin
                            o_cmd.stat = ST_RANGE;
                        end else begin
                            o_cmd.set_stat = 1'b0;
                            o_cmd.k_op     = K_CNT;
                            n_state        = S_INS_CHK;
                        end
                    end
                    MODE_DEL_FIRST, MODE_DEL_LAST, MODE_DEL_AT: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.stat = ST_EMPTY;
                        end else if (i_stat.tpos_ge_cnt) begin
                            o_cmd.stat = ST_RANGE;
                        end else begin
                            o_cmd.set_stat = 1'b0;
                            o_cmd.k_op     = K_TPOS;
                            n_state        = S_DEL_CHK;
                        end
                    end
                    MODE_SORT: begin
                        if (!i_stat.cnt_zero) begin
                            o_cmd.set_stat = 1'b0;
                            o_cmd.lim_load = 1'b1;
                            n_state        = S_SRT_PASS;
                        end
                    end
                    MODE_REVERSE: begin
                        o_cmd.set_stat = 1'b0;
                        o_cmd.k_op     = K_ZERO;
                        n_state        = S_REV_CHK;
                    end
                    MODE_READ: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.stat = ST_EMPTY;
                        end else if (i_stat.tpos_ge_cnt) begin
                            o_cmd.stat = ST_RANGE;
                        end else begin
                            o_cmd.set_stat = 1'b0;
                            o_cmd.rd_en    = 1'b1;
                            o_cmd.rd_sel   = RA_TPOS;
                            n_state        = S_RD_WT;
                        end
                    end
                    default: begin
                        // unused modes leave the list alone
                    end
                endcase
            end
            // Insert: move entries up from the tail, then drop the item in
            S_INS_CHK: begin
                if (i_stat.k_gt_tpos) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_KM1;
                    n_state      = S_INS_WR;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_asel  = WA_TPOS;
                    o_cmd.wr_dsel  = WD_VALUE;
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat     = ST_OK;
                    n_state        = S_FIN;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_asel = WA_K;
                o_cmd.wr_dsel = WD_RDATA;
                o_cmd.k_op    = K_DEC;
                n_state       = S_INS_CHK;
            end
            // Delete: move entries down over the gap
            S_DEL_CHK: begin
                if (i_stat.k_p1_lt_cnt) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_KP1;
                    n_state      = S_DEL_WR;
                end else begin
                    o_cmd.cnt_dec  = 1'b1;
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat     = ST_OK;
                    n_state        = S_FIN;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_asel = WA_K;
                o_cmd.wr_dsel = WD_RDATA;
                o_cmd.k_op    = K_INC;
                n_state       = S_DEL_CHK;
            end
            // Bubble sort: the running maximum rides along in register a
            S_SRT_PASS: begin
                if (i_stat.lim_zero) begin
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat     = ST_OK;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_ZERO;
                    o_cmd.k_op   = K_ZERO;
                    n_state      = S_SRT_A;
                end
            end
            S_SRT_A: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_KP1;
                n_state      = S_SRT_B;
            end
            S_SRT_B: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_asel = WA_K;
                o_cmd.wr_dsel = WD_MIN;
                o_cmd.a_max   = 1'b1;
                o_cmd.k_op    = K_INC;
                n_state       = S_SRT_NX;
            end
            S_SRT_NX: begin
                if (i_stat.k_eq_lim) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_asel = WA_K;
                    o_cmd.wr_dsel = WD_A;
                    o_cmd.lim_dec = 1'b1;
                    n_state       = S_SRT_PASS;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_KP1;
                    n_state      = S_SRT_B;
                end
            end
            // Reverse: swap entry k with its mirror
            S_REV_CHK: begin
                if (i_stat.k_lt_half) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_K;
                    n_state      = S_REV_RA;
                end else begin
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat     = ST_OK;
                    n_state        = S_FIN;
                end
            end
            S_REV_RA: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_MIR;
                n_state      = S_REV_RB;
            end
            S_REV_RB: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_asel = WA_K;
                o_cmd.wr_dsel = WD_RDATA;
                n_state       = S_REV_WB;
            end
            S_REV_WB: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_asel = WA_MIR;
                o_cmd.wr_dsel = WD_A;
                o_cmd.k_op    = K_INC;
                n_state       = S_REV_CHK;
            end
            S_RD_WT: begin
                o_cmd.take_rd  = 1'b1;
                o_cmd.set_stat = 1'b1;
                o_cmd.stat     = ST_OK;
                n_state        = S_FIN;
            end
            // Hand the result to the output register once it is free
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ale_datapath.sv =====
// Element memory, count, index registers and result register of the list engine.
`timescale 1ns / 1ps

module ale_datapath import ale_pkg::*; #(
    parameter int CAPACITY = ALE_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_position,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic [5:0]         o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    logic [31:0]   r_mem [CAPACITY];
    logic [31:0]   r_rdata;

    logic [3:0]    r_mode;
    logic [31:0]   r_value;
    logic [XW-1:0] r_tpos;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_lim;
    logic [31:0]   r_a;
    logic [1:0]    r_stat;
    logic [31:0]   r_rval;

    logic          r_ovalid;
    logic [1:0]    r_ostatus;
    logic [31:0]   r_orval;
    logic [5:0]    r_ocount;

    logic [XW-1:0] n_tpos;
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_km1;
    logic [CW-1:0] w_kp1;
    logic [CW-1:0] w_mir;
    logic [AW-1:0] w_ra;
    logic [AW-1:0] w_wa;
    logic [31:0]   w_wd;
    logic          w_gt;
    logic [31:0]   w_min;
    logic [31:0]   w_max;

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_km1    = r_k - CW'(1);
    assign w_kp1    = r_k + CW'(1);
    assign w_mir    = w_cnt_m1 - r_k;

    // Target position of the operation, fixed when the item is taken
    always_comb begin
        case (i_mode)
            MODE_PREPEND, MODE_DEL_FIRST: n_tpos = '0;
            MODE_APPEND:                  n_tpos = XW'(r_count);
            MODE_DEL_LAST:                n_tpos = XW'(w_cnt_m1);
            default:                      n_tpos = XW'(i_position);
        endcase
    end

    // Signed compare for the sort step
    assign w_gt  = $signed(r_a) > $signed(r_rdata);
    assign w_min = w_gt ? r_rdata : r_a;
    assign w_max = w_gt ? r_a : r_rdata;

    // Read address select
    always_comb begin
        case (i_cmd.rd_sel)
            RA_KM1:  w_ra = w_km1[AW-1:0];
            RA_KP1:  w_ra = w_kp1[AW-1:0];
            RA_K:    w_ra = r_k[AW-1:0];
            RA_TPOS: w_ra = r_tpos[AW-1:0];
            RA_MIR:  w_ra = w_mir[AW-1:0];
            default: w_ra = '0;
        endcase
    end

    // Write address and data select
    always_comb begin
        case (i_cmd.wr_asel)
            WA_TPOS: w_wa = r_tpos[AW-1:0];
            WA_MIR:  w_wa = w_mir[AW-1:0];
            default: w_wa = r_k[AW-1:0];
        endcase
        unique case (i_cmd.wr_dsel)
            WD_VALUE: w_wd = r_value;
            WD_RDATA: w_wd = r_rdata;
            WD_MIN:   w_wd = w_min;
            WD_A:     w_wd = r_a;
        endcase
    end

    // Element memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_ra];
        end
    end

    // Item latch, index counter and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_value;
            r_tpos  <= n_tpos;
            r_rval  <= '0;
        end
        case (i_cmd.k_op)
            K_CNT:   r_k <= r_count;
            K_TPOS:  r_k <= r_tpos[CW-1:0];
            K_ZERO:  r_k <= '0;
            K_INC:   r_k <= w_kp1;
            K_DEC:   r_k <= w_km1;
            default: r_k <= r_k;
        endcase
        if (i_cmd.lim_load) begin
            r_lim <= w_cnt_m1;
        end else if (i_cmd.lim_dec) begin
            r_lim <= r_lim - CW'(1);
        end
        if (i_cmd.cap_a) begin
            r_a <= r_rdata;
        end else if (i_cmd.a_max) begin
            r_a <= w_max;
        end
        if (i_cmd.set_stat) begin
            r_stat <= i_cmd.stat;
        end
        if (i_cmd.take_rd) begin
            r_rval <= r_rdata;
        end
    end

    // Element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= w_cnt_m1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ostatus <= r_stat;
            r_orval   <= r_rval;
            r_ocount  <= 6'(r_count);
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_read_value = r_orval;
    assign o_count      = r_ocount;

    // Status flags for the controller
    assign o_stat.mode        = r_mode;
    assign o_stat.cnt_zero    = (r_count == '0);
    assign o_stat.cnt_full    = (r_count == CW'(CAPACITY));
    assign o_stat.tpos_gt_cnt = (r_tpos > XW'(r_count));
    assign o_stat.tpos_ge_cnt = (r_tpos >= XW'(r_count));
    assign o_stat.k_gt_tpos   = (XW'(r_k) > r_tpos);
    assign o_stat.k_p1_lt_cnt = ((CW + 1)'(r_k) + (CW + 1)'(1)) < (CW + 1)'(r_count);
    assign o_stat.k_lt_half   = (r_k < (r_count >> 1));
    assign o_stat.lim_zero    = (r_lim == '0);
    assign o_stat.k_eq_lim    = (r_k == r_lim);
    assign o_stat.out_free    = !r_ovalid || i_out_ready;

endmodule
